@@ sv/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and sizes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int TASK_COUNT = 4;
  localparam int TASK_W     = $clog2(TASK_COUNT);
  localparam int IDX_W      = $clog2(TASK_COUNT + 1);

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Queue link value that marks the end of a queue.
  localparam idx_t QEND = idx_t'(TASK_COUNT);

  localparam logic [7:0]  TICK_DIV_RST = 8'h03;
  localparam logic [15:0] MASK_RST     = 16'h0007;

  typedef enum logic [1:0] {
    CFG_TICK_DIVIDE = 2'd0,
    CFG_READY_MASK  = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    K_TICK  = 3'd0,
    K_YIELD = 3'd1,
    K_SLEEP = 3'd2,
    K_ON    = 3'd3,
    K_OFF   = 3'd4,
    K_IDLE  = 3'd5,
    K_READ  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    M_FREE  = 2'd0,
    M_IDLE  = 2'd1,
    M_READY = 2'd2,
    M_SLEEP = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  task_req;
    logic [31:0] sleep_ticks;
  } evt_t;

  typedef struct packed {
    logic [3:0] current_task;
    logic       accepted;
    logic       switched;
  } res_t;

  function automatic task_t tk(idx_t v);
    return v[TASK_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rrts_core.sv @@
// ----------------------------------------------------------------------------
// rrts_core
// Task table and the sequencer that walks the linked ready and sleep queues
// one link per cycle for each kernel event.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_valid_i,
  input  wire  [1:0]        cfg_index_i,
  input  wire  [15:0]       cfg_data_i,
  output logic              idle_o,
  input  wire               start_i,
  input  rrts_pkg::evt_t    evt_i,
  output logic              res_valid_o,
  input  wire               res_ready_i,
  output rrts_pkg::res_t    res_o
);

  typedef enum logic [9:0] {
    S_RB       = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_START    = 10'b0000000100,
    S_SCAN     = 10'b0000001000,
    S_AP_START = 10'b0000010000,
    S_AP_WALK  = 10'b0000100000,
    S_RM_START = 10'b0001000000,
    S_RM_WALK  = 10'b0010000000,
    S_RESCHED  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    R_SCAN_APP  = 2'd0,
    R_SCAN_NEXT = 2'd1,
    R_RESCHED   = 2'd2,
    R_DONE      = 2'd3
  } ret_e;

  localparam int TC = rrts_pkg::TASK_COUNT;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   qsel_q, qsel_d;  // 0 ready queue, 1 sleep queue
  rrts_pkg::idx_t arg_q, arg_d, ptr_q, ptr_d, cnt_q, cnt_d;
  rrts_pkg::idx_t scan_t_q, scan_t_d, scan_nx_q, scan_nx_d, scan_i_q, scan_i_d;
  rrts_pkg::idx_t ready_head_q, ready_head_d, sleep_head_q, sleep_head_d;
  rrts_pkg::task_t run_q, run_d, prev_q, prev_d, rb_q, rb_d;
  logic   acc_q, acc_d;
  logic [2:0]  kind_q, kind_d;
  logic [3:0]  req_q, req_d;
  logic [31:0] ticks_q, ticks_d;
  logic [7:0]  tick_left_q, tick_left_d, tick_div_q, tick_div_d;
  logic [15:0] mask_q, mask_d;

  rrts_pkg::mode_e mode_q [TC];
  rrts_pkg::mode_e mode_d [TC];
  rrts_pkg::idx_t  next_q [TC];
  rrts_pkg::idx_t  next_d [TC];
  logic [31:0]     sleep_left_q [TC];
  logic [31:0]     sleep_left_d [TC];

  rrts_pkg::idx_t  head_cur, nptr, old_idx;
  rrts_pkg::task_t req_t, st;
  logic            req_ok, ret_go;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    qsel_d       = qsel_q;
    arg_d        = arg_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    scan_t_d     = scan_t_q;
    scan_nx_d    = scan_nx_q;
    scan_i_d     = scan_i_q;
    ready_head_d = ready_head_q;
    sleep_head_d = sleep_head_q;
    run_d        = run_q;
    prev_d       = prev_q;
    rb_d         = rb_q;
    acc_d        = acc_q;
    kind_d       = kind_q;
    req_d        = req_q;
    ticks_d      = ticks_q;
    tick_left_d  = tick_left_q;
    tick_div_d   = tick_div_q;
    mask_d       = mask_q;
    mode_d       = mode_q;
    next_d       = next_q;
    sleep_left_d = sleep_left_q;
    ret_go       = 1'b0;
    res_valid_o  = 1'b0;
    idle_o       = (state_q == S_IDLE);

    head_cur = qsel_q ? sleep_head_q : ready_head_q;
    nptr     = next_q[rrts_pkg::tk(ptr_q)];
    old_idx  = rrts_pkg::idx_t'(run_q);
    req_t    = req_q[rrts_pkg::TASK_W-1:0];
    req_ok   = ({1'b0, req_q} < 5'(TC));
    st       = rrts_pkg::tk(scan_t_q);

    case (state_q)
      S_RB: begin
        // Rebuild sweep from the top task down, so each masked task except task 0
        // links to the lowest masked task above it; task 0 is not queued.
        mode_d[rb_q]       = mask_q[rb_q] ? rrts_pkg::M_READY : rrts_pkg::M_FREE;
        sleep_left_d[rb_q] = '0;
        if ((rb_q != '0) && mask_q[rb_q]) begin
          next_d[rb_q] = ready_head_q;
          ready_head_d = rrts_pkg::idx_t'(rb_q);
        end else begin
          next_d[rb_q] = rrts_pkg::QEND;
        end
        if (rb_q == '0) begin
          state_d = S_IDLE;
        end else begin
          rb_d = rb_q - rrts_pkg::task_t'(1);
        end
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          if ((cfg_index_i == rrts_pkg::CFG_TICK_DIVIDE) ||
              (cfg_index_i == rrts_pkg::CFG_READY_MASK)) begin
            if (cfg_index_i == rrts_pkg::CFG_TICK_DIVIDE) begin
              tick_div_d  = cfg_data_i[7:0];
              tick_left_d = cfg_data_i[7:0];
            end else begin
              mask_d      = cfg_data_i;
              tick_left_d = tick_div_q;
            end
            ready_head_d = rrts_pkg::QEND;
            sleep_head_d = rrts_pkg::QEND;
            run_d        = '0;
            rb_d         = rrts_pkg::task_t'(TC - 1);
            state_d      = S_RB;
          end
        end else if (start_i) begin
          kind_d  = evt_i.kind;
          req_d   = evt_i.task_req;
          ticks_d = evt_i.sleep_ticks;
          prev_d  = run_q;
          acc_d   = 1'b0;
          state_d = S_START;
        end
      end
      S_START: begin
        case (kind_q)
          rrts_pkg::K_TICK: begin
            if (tick_left_q != 8'd0) begin
              tick_left_d = tick_left_q - 8'd1;
              state_d     = S_DONE;
            end else begin
              tick_left_d = tick_div_q;
              scan_t_d    = sleep_head_q;
              scan_i_d    = '0;
              state_d     = S_SCAN;
            end
          end
          rrts_pkg::K_YIELD: state_d = S_RESCHED;
          rrts_pkg::K_SLEEP: begin
            sleep_left_d[run_q] = ticks_q;
            mode_d[run_q]       = rrts_pkg::M_SLEEP;
            state_d             = S_RESCHED;
          end
          rrts_pkg::K_ON: begin
            state_d = S_RESCHED;
            if (req_ok && ((mode_q[req_t] == rrts_pkg::M_FREE) ||
                           (mode_q[req_t] == rrts_pkg::M_IDLE))) begin
              mode_d[req_t] = rrts_pkg::M_READY;
              acc_d         = 1'b1;
              arg_d         = rrts_pkg::idx_t'(req_t);
              qsel_d        = 1'b0;
              ret_d         = R_RESCHED;
              state_d       = S_AP_START;
            end
          end
          rrts_pkg::K_OFF: begin
            state_d = S_RESCHED;
            if (req_ok && ((mode_q[req_t] == rrts_pkg::M_READY) ||
                           (mode_q[req_t] == rrts_pkg::M_SLEEP))) begin
              qsel_d        = (mode_q[req_t] == rrts_pkg::M_SLEEP);
              mode_d[req_t] = rrts_pkg::M_IDLE;
              acc_d         = 1'b1;
              arg_d         = rrts_pkg::idx_t'(req_t);
              ret_d         = R_RESCHED;
              state_d       = S_RM_START;
            end
          end
          rrts_pkg::K_IDLE: begin
            mode_d[run_q] = rrts_pkg::M_IDLE;
            state_d       = S_RESCHED;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        // The successor is latched before the entry is unlinked.
        if ((scan_i_q != rrts_pkg::QEND) && (scan_t_q < rrts_pkg::QEND)) begin
          scan_nx_d = next_q[st];
          if (sleep_left_q[st] == 32'd0) begin
            mode_d[st] = rrts_pkg::M_READY;
            arg_d      = scan_t_q;
            qsel_d     = 1'b1;
            ret_d      = R_SCAN_APP;
            state_d    = S_RM_START;
          end else begin
            sleep_left_d[st] = sleep_left_q[st] - 32'd1;
            scan_t_d         = next_q[st];
            scan_i_d         = scan_i_q + rrts_pkg::idx_t'(1);
          end
        end else begin
          state_d = S_RESCHED;
        end
      end
      S_AP_START: begin
        if (head_cur >= rrts_pkg::QEND) begin
          if (qsel_q) sleep_head_d = arg_q;
          else        ready_head_d = arg_q;
          next_d[rrts_pkg::tk(arg_q)] = rrts_pkg::QEND;
          ret_go = 1'b1;
        end else begin
          ptr_d   = head_cur;
          cnt_d   = '0;
          state_d = S_AP_WALK;
        end
      end
      S_AP_WALK: begin
        if ((cnt_q == rrts_pkg::QEND) || (nptr >= rrts_pkg::QEND)) begin
          next_d[rrts_pkg::tk(ptr_q)] = arg_q;
          next_d[rrts_pkg::tk(arg_q)] = rrts_pkg::QEND;
          ret_go = 1'b1;
        end else begin
          ptr_d = nptr;
          cnt_d = cnt_q + rrts_pkg::idx_t'(1);
        end
      end
      S_RM_START: begin
        if ((arg_q >= rrts_pkg::QEND) || (head_cur >= rrts_pkg::QEND)) begin
          ret_go = 1'b1;
        end else if (head_cur == arg_q) begin
          if (qsel_q) sleep_head_d = next_q[rrts_pkg::tk(arg_q)];
          else        ready_head_d = next_q[rrts_pkg::tk(arg_q)];
          ret_go = 1'b1;
        end else begin
          ptr_d   = head_cur;
          cnt_d   = '0;
          state_d = S_RM_WALK;
        end
      end
      S_RM_WALK: begin
        if ((cnt_q == rrts_pkg::QEND) || (nptr >= rrts_pkg::QEND)) begin
          ret_go = 1'b1;
        end else if (nptr == arg_q) begin
          next_d[rrts_pkg::tk(ptr_q)] = next_q[rrts_pkg::tk(arg_q)];
          ret_go = 1'b1;
        end else begin
          ptr_d = nptr;
          cnt_d = cnt_q + rrts_pkg::idx_t'(1);
        end
      end
      S_RESCHED: begin
        state_d = S_DONE;
        if (ready_head_q < rrts_pkg::QEND) begin
          ready_head_d = next_q[rrts_pkg::tk(ready_head_q)];
          run_d        = rrts_pkg::tk(ready_head_q);
          if ((mode_q[run_q] == rrts_pkg::M_READY) ||
              (mode_q[run_q] == rrts_pkg::M_SLEEP)) begin
            arg_d   = old_idx;
            qsel_d  = (mode_q[run_q] == rrts_pkg::M_SLEEP);
            ret_d   = R_DONE;
            state_d = S_AP_START;
          end
        end else begin
          ready_head_d = rrts_pkg::QEND;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (ret_go) begin
      case (ret_q)
        R_SCAN_APP: begin
          arg_d   = scan_t_q;
          qsel_d  = 1'b0;
          ret_d   = R_SCAN_NEXT;
          state_d = S_AP_START;
        end
        R_SCAN_NEXT: begin
          scan_t_d = scan_nx_q;
          scan_i_d = scan_i_q + rrts_pkg::idx_t'(1);
          state_d  = S_SCAN;
        end
        R_RESCHED: state_d = S_RESCHED;
        default:   state_d = S_DONE;
      endcase
    end
  end

  assign res_o.current_task = 4'(run_q);
  assign res_o.accepted     = acc_q;
  assign res_o.switched     = (run_q != prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RB;
      ret_q        <= R_DONE;
      rb_q         <= rrts_pkg::task_t'(TC - 1);
      tick_div_q   <= rrts_pkg::TICK_DIV_RST;
      tick_left_q  <= rrts_pkg::TICK_DIV_RST;
      mask_q       <= rrts_pkg::MASK_RST;
      ready_head_q <= rrts_pkg::QEND;
      sleep_head_q <= rrts_pkg::QEND;
      run_q        <= '0;
      prev_q       <= '0;
      acc_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      rb_q         <= rb_d;
      tick_div_q   <= tick_div_d;
      tick_left_q  <= tick_left_d;
      mask_q       <= mask_d;
      ready_head_q <= ready_head_d;
      sleep_head_q <= sleep_head_d;
      run_q        <= run_d;
      prev_q       <= prev_d;
      acc_q        <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qsel_q       <= qsel_d;
    arg_q        <= arg_d;
    ptr_q        <= ptr_d;
    cnt_q        <= cnt_d;
    scan_t_q     <= scan_t_d;
    scan_nx_q    <= scan_nx_d;
    scan_i_q     <= scan_i_d;
    kind_q       <= kind_d;
    req_q        <= req_d;
    ticks_q      <= ticks_d;
    mode_q       <= mode_d;
    next_q       <= next_d;
    sleep_left_q <= sleep_left_d;
  end

endmodule

`default_nettype wire

@@ sv/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Kernel event scheduler over a fixed task table with ready and sleep queues.
// ----------------------------------------------------------------------------
// How long each accepted event takes depends on the queue links that the
// sequencer walks, one link per cycle, through a single table read path. A read
// current or an unexpired tick walks no queue link. The worst case is a timer
// expiry that wakes three sleepers into an empty ready queue and then requeues
// a ready task. A stalled output holds the block in its final state until the
// output register frees up. The input is not ready while an event is in
// progress. After reset, and after every write to the tick divide or ready mask
// register, a rebuild sweep over every task reloads the task table before the
// next event is taken.
`default_nettype none

module round_robin_task_scheduler (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // task_req[3:0], sleep_ticks[35:4], zero pad
  input  wire  [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // current_task[3:0], accepted[4], switched[5]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  rrts_pkg::evt_t evt;
  rrts_pkg::res_t res, out_q;
  logic idle, res_valid, res_ready, out_valid_q;

  assign evt.kind        = s_axis_tuser;
  assign evt.task_req    = s_axis_tdata[3:0];
  assign evt.sleep_ticks = s_axis_tdata[35:4];

  assign cfg_ready_o   = idle;
  assign s_axis_tready = idle & ~cfg_valid_i;
  assign res_ready     = ~out_valid_q | m_axis_tready;

  rrts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .idle_o      (idle),
    .start_i     (s_axis_tvalid & s_axis_tready),
    .evt_i       (evt),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register holds a finished transaction until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.switched, out_q.accepted, out_q.current_task};

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Round-robin task scheduler testbench
// Drives kernel events through the stream input, predicts the scheduled
// task for each transaction with a behavioral copy of the task table, and
// compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rrts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  task_req;
    logic [31:0] sleep_ticks;
    bit          drain_first;
  } event_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  round_robin_task_scheduler uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Scheduler state mirror.
  logic [7:0]  div_reg;
  logic [15:0] mask_reg;
  mode_e       mode_tbl [TASK_COUNT];
  int          link_tbl [TASK_COUNT];
  logic [31:0] sleep_tbl [TASK_COUNT];
  int          ready_hd, sleep_hd, running, tick_cnt;

  event_item_t pending_events[$];
  res_t        expected_results[$];
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          cfg_busy = 1'b0;
  bit          in_fire = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void enqueue_tail(ref int head, input int t);
    int p;
    if (head >= TASK_COUNT) begin
      head = t;
    end else begin
      p = head;
      for (int i = 0; i < TASK_COUNT; i++) begin
        if (link_tbl[p] >= TASK_COUNT) break;
        p = link_tbl[p];
      end
      link_tbl[p] = t;
    end
    link_tbl[t] = TASK_COUNT;
  endfunction

  function automatic void unlink(ref int head, input int t);
    int p, n;
    if (head >= TASK_COUNT) return;
    if (head == t) begin
      head = link_tbl[t];
      return;
    end
    p = head;
    for (int i = 0; i < TASK_COUNT; i++) begin
      n = link_tbl[p];
      if (n >= TASK_COUNT) return;
      if (n == t) begin
        link_tbl[p] = link_tbl[t];
        return;
      end
      p = n;
    end
  endfunction

  function automatic void restart_table();
    for (int t = 0; t < TASK_COUNT; t++) begin
      mode_tbl[t]  = mask_reg[t] ? M_READY : M_FREE;
      link_tbl[t]  = TASK_COUNT;
      sleep_tbl[t] = '0;
    end
    ready_hd = TASK_COUNT;
    sleep_hd = TASK_COUNT;
    for (int t = 1; t < TASK_COUNT; t++)
      if (mode_tbl[t] == M_READY) enqueue_tail(ready_hd, t);
    running  = 0;
    tick_cnt = div_reg;
  endfunction

  function automatic void pick_next();
    int old, n;
    old = running;
    n = ready_hd;
    if (n >= TASK_COUNT) return;
    ready_hd = link_tbl[n];
    running = n;
    if (mode_tbl[old] == M_READY) enqueue_tail(ready_hd, old);
    else if (mode_tbl[old] == M_SLEEP) enqueue_tail(sleep_hd, old);
  endfunction

  function automatic void wake_sleepers();
    int t, nx;
    t = sleep_hd;
    for (int i = 0; i < TASK_COUNT && t < TASK_COUNT; i++) begin
      nx = link_tbl[t];
      if (sleep_tbl[t] == 0) begin
        unlink(sleep_hd, t);
        mode_tbl[t] = M_READY;
        enqueue_tail(ready_hd, t);
      end else begin
        sleep_tbl[t]--;
      end
      t = nx;
    end
  endfunction

  function automatic res_t schedule_event(event_item_t ev);
    res_t r;
    int   prev;
    bit   acc;
    int   t;
    prev = running;
    acc = 1'b0;
    t = ev.task_req;
    case (ev.kind)
      K_TICK: begin
        if (tick_cnt != 0) begin
          tick_cnt--;
        end else begin
          tick_cnt = div_reg;
          wake_sleepers();
          pick_next();
        end
      end
      K_YIELD: pick_next();
      K_SLEEP: begin
        sleep_tbl[running] = ev.sleep_ticks;
        mode_tbl[running] = M_SLEEP;
        pick_next();
      end
      K_ON: begin
        if (t < TASK_COUNT && (mode_tbl[t] == M_FREE || mode_tbl[t] == M_IDLE)) begin
          mode_tbl[t] = M_READY;
          enqueue_tail(ready_hd, t);
          acc = 1'b1;
        end
        pick_next();
      end
      K_OFF: begin
        if (t < TASK_COUNT && mode_tbl[t] == M_READY) begin
          unlink(ready_hd, t);
          mode_tbl[t] = M_IDLE;
          acc = 1'b1;
        end else if (t < TASK_COUNT && mode_tbl[t] == M_SLEEP) begin
          unlink(sleep_hd, t);
          mode_tbl[t] = M_IDLE;
          acc = 1'b1;
        end
        pick_next();
      end
      K_IDLE: begin
        mode_tbl[running] = M_IDLE;
        pick_next();
      end
      default: ;
    endcase
    r.current_task = 4'(running);
    r.accepted     = acc;
    r.switched     = (running != prev);
    return r;
  endfunction

  function automatic event_item_t make_event(logic [2:0] k, logic [3:0] t, logic [31:0] s);
    event_item_t e;
    e.kind = k;
    e.task_req = t;
    e.sleep_ticks = s;
    e.drain_first = 1'b0;
    return e;
  endfunction

  function automatic event_item_t random_event();
    logic [31:0] s;
    int          r;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    s = $urandom;
      2:       s = 32'hFFFF_FFFF;
      default: s = $urandom_range(0, 4);
    endcase
    // Ticks dominate so that sleepers wake; task numbers mostly in range.
    if (r < 40) return make_event(K_TICK, 4'($urandom), s);
    else if (r < 95)
      return make_event(3'($urandom_range(1, 7)),
                        ($urandom_range(0, 9) == 0) ? 4'($urandom) :
                        4'($urandom_range(0, TASK_COUNT - 1)), s);
    else return make_event(3'($urandom), 4'($urandom), $urandom);
  endfunction

  // Input driver: changes inputs on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        // Hold the offered transaction until it is taken.
      end else if (pending_events.size() != 0 && !cfg_busy &&
                   !(pending_events[0].drain_first && expected_results.size() != 0) &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_events[0].kind;
        s_axis_tdata  <= {4'b0, pending_events[0].sleep_ticks, pending_events[0].task_req};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk_i) begin
    res_t got, want;
    int   quiet_next;
    if (rst_ni) begin
      quiet_next = quiet_cycles + 1;
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(schedule_event(pending_events.pop_front()));
        quiet_next = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_next = 0;
        got.current_task = m_axis_tdata[3:0];
        got.accepted     = m_axis_tdata[4];
        got.switched     = m_axis_tdata[5];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction %h", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected task %0d acc %0b sw %0b, got task %0d acc %0b sw %0b",
                       want.current_task, want.accepted, want.switched,
                       got.current_task, got.accepted, got.switched);
          end
        end
      end
      quiet_cycles <= quiet_next;
      if (quiet_next >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_quiet();
    while (pending_events.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    wait_quiet();
    cfg_busy = 1'b1;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TICK_DIVIDE) div_reg = value[7:0];
    else mask_reg = value;
    restart_table();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_events.push_back(random_event());
    wait_quiet();
  endtask

  initial begin
    event_item_t e;
    div_reg  = TICK_DIV_RST;
    mask_reg = MASK_RST;
    restart_table();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every kind, field extremes, out-of-range tasks, empty queue.
    pending_events.push_back(make_event(K_READ, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_YIELD, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_SLEEP, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_SLEEP, 4'd0, 32'hFFFF_FFFF));
    for (int i = 0; i < 4; i++) pending_events.push_back(make_event(K_TICK, 4'hF, 32'd0));
    pending_events.push_back(make_event(K_ON, 4'd3, 32'd0));
    pending_events.push_back(make_event(K_ON, 4'd15, 32'd0));
    pending_events.push_back(make_event(K_OFF, 4'd15, 32'hFFFF_FFFF));
    pending_events.push_back(make_event(K_OFF, 4'd1, 32'd0));
    pending_events.push_back(make_event(K_OFF, 4'd2, 32'd0));
    pending_events.push_back(make_event(K_IDLE, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_IDLE, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_SLEEP, 4'd0, 32'd1));
    pending_events.push_back(make_event(3'd7, 4'd5, 32'hA5A5_5A5A));
    pending_events.push_back(make_event(K_ON, 4'd0, 32'd0));
    pending_events.push_back(make_event(K_YIELD, 4'd0, 32'd0));
    wait_quiet();

    write_register(CFG_TICK_DIVIDE, 16'd0);
    write_register(CFG_READY_MASK, 16'hFFFF);
    run_random(450);

    send_idle_pct = 48;
    write_register(CFG_READY_MASK, 16'h0000);
    run_random(200);
    // Sender holds off until all results are in.
    e = random_event();
    e.drain_first = 1'b1;
    pending_events.push_back(e);
    run_random(250);

    send_idle_pct = 0;
    recv_stall_pct = 48;
    write_register(CFG_TICK_DIVIDE, 16'd255);
    write_register(CFG_READY_MASK, 16'h000A);
    run_random(450);

    send_idle_pct = 30;
    recv_stall_pct = 30;
    write_register(CFG_TICK_DIVIDE, 16'd1);
    write_register(CFG_READY_MASK, 16'h00F5);
    run_random(500);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
